// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthands for concurrent assertions clocked on clk_i, with and without
// the active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/htfc_pkg.sv
// ----------------------------------------------------------------------------
// Frame checker package
// Constants, status codes and the controller/datapath command and status
// bundles of the humidity and temperature frame checker.
// ----------------------------------------------------------------------------
package htfc_pkg;

  // CRC-8 of the sensor: polynomial x^8 + x^5 + x^4 + 1, seeded with all ones.
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Conversion scale factors in hundredths (175.00 and 125.00 over full scale).
  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [14:0] HumidScale = 15'd12500;
  localparam logic [15:0] TempOffset = 16'd4500;
  localparam logic [14:0] HumidOffset = 15'd600;
  localparam logic [14:0] HumidMax    = 15'd10000;

  // Sequencing: one CRC bit per cycle, one quotient bit per cycle.
  localparam int StepW = 4;
  localparam logic [StepW-1:0] CrcLast = StepW'(16 - 1);
  localparam logic [StepW-1:0] DivLast = StepW'(15 - 1);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TEMP_CRC  = 2'd1,
    STATUS_HUMID_CRC = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted frame and seed both CRCs
    logic crc_step;   // advance both CRCs by one message bit
    logic check;      // compare CRCs, accumulate on a good frame
    logic mul_load;   // scale a sum and seed the divider
    logic mul_sel;    // 0 selects temperature, 1 humidity
    logic div_step;   // one restoring division step
    logic save_temp;  // keep the temperature quotient
    logic out_load;   // fill the result register and clear the sums
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic crc_bad;    // either received CRC differs from the computed one
    logic set_done;   // this good frame completes the averaging set
    logic out_full;   // the result register still holds an untaken result
  } sts_t;

endpackage

// File: hdl/htfc_if.sv
// ----------------------------------------------------------------------------
// Frame checker channels
// Valid/ready channels for the incoming sensor frame and the outgoing result.
// ----------------------------------------------------------------------------
interface htfc_frame_if;
  logic        valid;
  logic        ready;
  logic [15:0] temp_word;
  logic [7:0]  temp_crc;
  logic [15:0] humid_word;
  logic [7:0]  humid_crc;

  modport source (output valid, output temp_word, output temp_crc,
                  output humid_word, output humid_crc, input ready);
  modport sink   (input valid, input temp_word, input temp_crc,
                  input humid_word, input humid_crc, output ready);
endinterface

interface htfc_result_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [1:0]         status;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output status, input ready);
  modport sink   (input valid, input temperature_centi, input humidity_centi,
                  input status, output ready);
endinterface

// File: hdl/htfc_ctrl.sv
// ----------------------------------------------------------------------------
// Frame checker controller
// Sequences capture, bit-serial CRC, accumulation, two serial divisions and
// the result write.
// ----------------------------------------------------------------------------
module htfc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  htfc_pkg::sts_t sts_i,
  output htfc_pkg::cmd_t cmd_o
);
  import htfc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CRC   = 8'b0000_0010,
    ST_CHECK = 8'b0000_0100,
    ST_MULT  = 8'b0000_1000,
    ST_DIVT  = 8'b0001_0000,
    ST_MULH  = 8'b0010_0000,
    ST_DIVH  = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state, step counter and commands.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_CRC;
        end
      end
      ST_CRC: begin
        cmd_o.crc_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == CrcLast) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.crc_bad) begin
          state_d = ST_EMIT;
        end else if (sts_i.set_done) begin
          state_d = ST_MULT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MULT: begin
        cmd_o.mul_load = 1'b1;
        step_d         = '0;
        state_d        = ST_DIVT;
      end
      ST_DIVT: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == DivLast) begin
          state_d = ST_MULH;
        end
      end
      ST_MULH: begin
        cmd_o.save_temp = 1'b1;
        cmd_o.mul_load  = 1'b1;
        cmd_o.mul_sel   = 1'b1;
        step_d          = '0;
        state_d         = ST_DIVH;
      end
      ST_DIVH: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == DivLast) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// File: hdl/htfc_datapath.sv
// ----------------------------------------------------------------------------
// Frame checker datapath
// Frame capture, two bit-serial CRC-8 registers, running sums, a shared
// scaling multiplier, a restoring divider and the result register.
// ----------------------------------------------------------------------------
module htfc_datapath #(
  parameter int MAX_SAMPLES = 255
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  htfc_frame_if.sink     frame_i,
  htfc_result_if.source  result_o,
  input  htfc_pkg::cmd_t cmd_i,
  output htfc_pkg::sts_t sts_o
);
  import htfc_pkg::*;

  localparam logic [15:0] MaxSamples = 16'(MAX_SAMPLES);

  // Configuration and accumulation state.
  logic [7:0]  target_q;
  logic [23:0] temp_sum_q, humid_sum_q;
  logic [7:0]  samples_q;
  status_e     code_q;

  // Captured frame; the words rotate through the CRC and come back whole.
  logic [15:0] tword_q, hword_q;
  logic [7:0]  tcrc_rx_q, hcrc_rx_q;
  logic [7:0]  tcrc_q, hcrc_q;

  // Divider state.
  logic [23:0] den_q, rem_q;
  logic [14:0] low_q, quot_q, tq_q;

  // Result register.
  logic               out_valid_q;
  logic signed [14:0] out_temp_q;
  logic [13:0]        out_humid_q;
  logic [1:0]         out_status_q;

  function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic msg_bit);
    logic [7:0] shifted;
    shifted = {crc[6:0], 1'b0};
    return (crc[7] ^ msg_bit) ? (shifted ^ CrcPoly) : shifted;
  endfunction

  // Effective set length: zero means one, capped at the parameter.
  logic [7:0] target_nz, target_eff;
  logic [8:0] samples_next;
  always_comb begin
    target_nz  = (target_q == 8'd0) ? 8'd1 : target_q;
    target_eff = (MaxSamples < {8'd0, target_nz}) ? MaxSamples[7:0] : target_nz;
    samples_next = {1'b0, samples_q} + 9'd1;
  end

  logic bad_t, bad_h;
  assign bad_t = (tcrc_q != tcrc_rx_q);
  assign bad_h = (hcrc_q != hcrc_rx_q);

  assign sts_o.crc_bad  = bad_t | bad_h;
  assign sts_o.set_done = (samples_next >= {1'b0, target_eff});
  assign sts_o.out_full = out_valid_q;

  // Scaling multiply: 15 by 24 bits into the dividend.
  logic [38:0] prod;
  logic [23:0] mul_operand;
  logic [14:0] mul_coeff;
  always_comb begin
    mul_operand = cmd_i.mul_sel ? humid_sum_q : temp_sum_q;
    mul_coeff   = cmd_i.mul_sel ? HumidScale : TempScale;
    prod        = 39'(mul_operand) * 39'(mul_coeff);
  end

  // One restoring division step; the quotient is known to fit in 15 bits.
  logic [24:0] trial;
  logic [25:0] diff;
  assign trial = {rem_q, low_q[14]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};

  // Conversion of the two quotients to the result values.
  logic signed [15:0] temp_full;
  logic [13:0]        humid_clip;
  always_comb begin
    temp_full = $signed({1'b0, tq_q}) - $signed(TempOffset);
    if (quot_q < HumidOffset) begin
      humid_clip = 14'd0;
    end else if (quot_q - HumidOffset > HumidMax) begin
      humid_clip = HumidMax[13:0];
    end else begin
      humid_clip = 14'(quot_q - HumidOffset);
    end
  end

  // Control state: configuration, sums, count, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= 8'd1;
      temp_sum_q  <= '0;
      humid_sum_q <= '0;
      samples_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      if (cmd_i.check && !(bad_t || bad_h)) begin
        temp_sum_q  <= temp_sum_q + 24'(tword_q);
        humid_sum_q <= humid_sum_q + 24'(hword_q);
        samples_q   <= samples_next[7:0];
      end
      if (cmd_i.out_load) begin
        temp_sum_q  <= '0;
        humid_sum_q <= '0;
        samples_q   <= '0;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: frame, CRCs, divider and result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tword_q   <= frame_i.temp_word;
      hword_q   <= frame_i.humid_word;
      tcrc_rx_q <= frame_i.temp_crc;
      hcrc_rx_q <= frame_i.humid_crc;
      tcrc_q    <= CrcInit;
      hcrc_q    <= CrcInit;
    end
    if (cmd_i.crc_step) begin
      tcrc_q  <= crc_bit(tcrc_q, tword_q[15]);
      hcrc_q  <= crc_bit(hcrc_q, hword_q[15]);
      tword_q <= {tword_q[14:0], tword_q[15]};
      hword_q <= {hword_q[14:0], hword_q[15]};
    end
    if (cmd_i.check) begin
      code_q <= bad_t ? STATUS_TEMP_CRC : (bad_h ? STATUS_HUMID_CRC : STATUS_OK);
    end
    if (cmd_i.save_temp) begin
      tq_q <= quot_q;
    end
    if (cmd_i.mul_load) begin
      rem_q  <= prod[38:15];
      low_q  <= prod[14:0];
      quot_q <= '0;
      den_q  <= {samples_q, 16'd0} - {16'd0, samples_q};
    end else if (cmd_i.div_step) begin
      rem_q  <= diff[25] ? trial[23:0] : diff[23:0];
      low_q  <= {low_q[13:0], 1'b0};
      quot_q <= {quot_q[13:0], ~diff[25]};
    end
    if (cmd_i.out_load) begin
      out_status_q <= code_q;
      if (code_q == STATUS_OK) begin
        out_temp_q  <= temp_full[14:0];
        out_humid_q <= humid_clip;
      end else begin
        out_temp_q  <= '0;
        out_humid_q <= '0;
      end
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.temperature_centi = out_temp_q;
  assign result_o.humidity_centi    = out_humid_q;
  assign result_o.status            = out_status_q;

endmodule

// File: hdl/humidity_temp_frame_checker_core.sv
// ----------------------------------------------------------------------------
// Humidity and temperature frame checker
// Checks the two CRC-8 bytes of each sensor response, averages good frames
// and reports temperature and humidity in hundredths.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Handshake     Contents
//  frame_i    in         valid/ready   temp_word, temp_crc, humid_word, humid_crc
//  result_o   out        valid/ready   temperature_centi, humidity_centi, status
//  cfg        in         write enable  sample_count_target (8 bits)
//
// A new frame is accepted only once the previous one is finished. Every frame
// passes through the one-bit-per-cycle CRC registers; one that fails a CRC also
// writes an error result, and one that completes a set adds two 15-step restoring divisions.
// A waiting result stalls the block only when the next result is ready to be
// written. Reset clears the sums, count and handshake state and sets the
// target to one; no clearing pass is needed.
`include "assert_macros.svh"

module humidity_temp_frame_checker_core #(
  parameter int MAX_SAMPLES = 255
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  htfc_frame_if.sink    frame_i,
  htfc_result_if.source result_o
);
  import htfc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  htfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frame_i.valid),
    .in_ready_o (frame_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  htfc_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (frame_i),
    .result_o    (result_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // A transaction on the frame channel leaves the block busy in the next cycle.
  `ASSERT_CLK(a_busy_after_accept,
    (frame_i.valid && frame_i.ready) |=> !frame_i.ready,
    "frame accepted while busy")

  // A result is written only into an empty result register.
  `ASSERT_CLK(a_no_overwrite, cmd.out_load |-> !sts.out_full, "result register overwritten")

  // Error results carry zero measurement fields.
  `ASSERT_CLK(a_err_zero,
    (result_o.valid && result_o.status != 2'(STATUS_OK)) |->
      (result_o.temperature_centi == 15'sd0 && result_o.humidity_centi == 14'd0),
    "error result with nonzero values")

  // Humidity never leaves its clipped range.
  `ASSERT_CLK(a_humid_range,
    result_o.valid |-> (result_o.humidity_centi <= HumidMax[13:0]),
    "humidity out of range")

endmodule
